[sv/thbb_pkg.sv]
// shared types, widths and reset values for the timed heater controller
`default_nettype none

package thbb_pkg;

  localparam int unsigned TempW   = 13;
  localparam int unsigned TargetW = 12;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TargetW-1:0] TargetTempRst   = TargetW'(1400);
  localparam logic [TimeW-1:0]   LinkTimeoutRst  = TimeW'(200);
  localparam logic [TimeW-1:0]   MaxOnRst        = TimeW'(100);
  localparam logic [TimeW-1:0]   MinOffRst       = TimeW'(10);

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] CfgTargetTemp  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLinkTimeout = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxOn       = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMinOff      = 2'd3;

  typedef enum logic [1:0] {
    LedNone  = 2'd0,
    LedGreen = 2'd1,
    LedRed   = 2'd2,
    LedBlue  = 2'd3
  } led_e;

  typedef struct packed {
    logic [TargetW-1:0] target_temp;
    logic [TimeW-1:0]   link_timeout;
    logic [TimeW-1:0]   max_on;
    logic [TimeW-1:0]   min_off;
  } cfg_t;

  typedef struct packed {
    logic heater_on;
    led_e led_command;
    logic link_alive;
  } res_t;

endpackage

`default_nettype wire

[sv/timed_heater_bang_bang_controller.sv]
// an accepted word is held in the input register, then moves into the result register
// throughput: one word per cycle; the input register empties into the result
// register each cycle the result side is free or being taken
// the decision is one pass of counters, a 14 bit compare and muxes
// reset: asynchronous, active low; heater off, link dead, timers and held
// temperature zero, config registers at their documented defaults
`default_nettype none

module timed_heater_bang_bang_controller (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               op_i,
  input  wire logic signed [thbb_pkg::TempW-1:0]  tip_reading_i,
  // output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    heater_on_o,
  output logic [1:0]                              led_command_o,
  output logic                                    link_alive_o,
  // config write port
  input  wire logic                               cfg_we_i,
  input  wire logic [thbb_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [thbb_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import thbb_pkg::*;

  // input register
  logic                    in_valid_q;
  logic                    op_q;
  logic signed [TempW-1:0] tip_q;

  // result register
  logic                    out_valid_q, out_valid_d;
  res_t                    res_q;
  res_t                    res_next;

  cfg_t                    cfg;
  logic                    advance;
  logic                    step;

  // result slot is free when empty or being taken this cycle
  assign advance    = !out_valid_q || !out_stall_i;
  // the held word moves on when the result slot frees up
  assign step       = in_valid_q && advance;
  // the input register can take a new word when empty or whenever its current one leaves
  assign in_stall_o = in_valid_q && !advance;

  thbb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // state only advances when a word moves into the result register
  thbb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .op_i          (op_q),
    .tip_reading_i (tip_q),
    .cfg_i         (cfg),
    .res_o         (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload carries no reset
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      op_q  <= op_i;
      tip_q <= tip_reading_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign heater_on_o   = res_q.heater_on;
  assign led_command_o = res_q.led_command;
  assign link_alive_o  = res_q.link_alive;

endmodule

`default_nettype wire

[sv/thbb_cfg.sv]
// configuration register file for the timed heater controller
`default_nettype none

module thbb_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [thbb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [thbb_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output thbb_pkg::cfg_t                      cfg_o
);
  import thbb_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTargetTemp:  cfg_d.target_temp  = cfg_wdata_i[TargetW-1:0];
        CfgLinkTimeout: cfg_d.link_timeout = cfg_wdata_i[TimeW-1:0];
        CfgMaxOn:       cfg_d.max_on       = cfg_wdata_i[TimeW-1:0];
        CfgMinOff:      cfg_d.min_off      = cfg_wdata_i[TimeW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_temp  <= TargetTempRst;
      cfg_q.link_timeout <= LinkTimeoutRst;
      cfg_q.max_on       <= MaxOnRst;
      cfg_q.min_off      <= MinOffRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[sv/thbb_ctrl.sv]
// heater state, watchdog and burst timers with the on/off decision
`default_nettype none

module thbb_ctrl (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               step_i,
  input  wire logic                               op_i,
  input  wire logic signed [thbb_pkg::TempW-1:0]  tip_reading_i,
  input  wire thbb_pkg::cfg_t                     cfg_i,
  output thbb_pkg::res_t                          res_o
);
  import thbb_pkg::*;

  logic                    heater_q, heater_d;
  logic signed [TempW-1:0] held_q, held_d;
  logic [TimeW-1:0]        link_q, link_d;
  logic [TimeW-1:0]        on_q, on_d;
  logic [TimeW-1:0]        off_q, off_d;
  logic                    alive;
  logic                    at_target;
  logic                    on_load, off_load;
  led_e                    led;

  always_comb begin
    link_d = (link_q != '0) ? link_q - TimeW'(1) : '0;
    held_d = held_q;
    if (op_i) begin
      link_d = cfg_i.link_timeout;
      if (tip_reading_i > 0) begin
        held_d = tip_reading_i;
      end
    end
    alive = link_d != '0;
    // compare in one extra bit so the unsigned target stays positive
    at_target = $signed({held_d[TempW-1], held_d})
                >= $signed({2'b00, cfg_i.target_temp});

    heater_d = heater_q;
    on_load  = 1'b0;
    off_load = 1'b0;
    led      = LedNone;
    if (alive) begin
      if (!heater_q) begin
        if (at_target) begin
          led = LedGreen;
        end else if (off_q == '0) begin
          heater_d = 1'b1;
          on_load  = 1'b1;
          led      = LedRed;
        end
      end else if (on_q == '0 || at_target) begin
        heater_d = 1'b0;
        off_load = 1'b1;
        led      = LedBlue;
      end
    end else begin
      heater_d = 1'b0;
    end

    on_d  = on_load  ? cfg_i.max_on  : ((on_q  != '0) ? on_q  - TimeW'(1) : '0);
    off_d = off_load ? cfg_i.min_off : ((off_q != '0) ? off_q - TimeW'(1) : '0);

    res_o.heater_on   = heater_d;
    res_o.led_command = led;
    res_o.link_alive  = alive;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heater_q <= 1'b0;
      held_q   <= '0;
      link_q   <= '0;
      on_q     <= '0;
      off_q    <= '0;
    end else if (step_i) begin
      heater_q <= heater_d;
      held_q   <= held_d;
      link_q   <= link_d;
      on_q     <= on_d;
      off_q    <= off_d;
    end
  end

endmodule

`default_nettype wire

[sv/thbb_chk.sv]
// port level checker for the timed heater controller, bound to the top level
`default_nettype none

module thbb_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       heater_on_o,
  input wire logic [1:0] led_command_o,
  input wire logic       link_alive_o
);
  import thbb_pkg::*;

  // a dead link always leaves the heater off with no led
  a_dead_link_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !link_alive_o) |-> (!heater_on_o && led_command_o == LedNone))
    else $error("heater on or led set with link dead");

  // red means just switched on, blue and green mean off
  a_led_vs_heater: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((led_command_o == LedRed) == heater_on_o
                     || led_command_o == LedNone))
    else $error("led command disagrees with heater state");

  // two results in a row cannot both switch the heater on
  a_no_double_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && led_command_o == LedRed) |=>
      !(out_valid_o && led_command_o == LedRed && heater_on_o
        && $past(heater_on_o)))
    else $error("heater switched on twice in a row");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(heater_on_o) && $stable(led_command_o)
       && $stable(link_alive_o)))
    else $error("stalled result word changed");

endmodule

bind timed_heater_bang_bang_controller thbb_chk u_thbb_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .heater_on_o   (heater_on_o),
  .led_command_o (led_command_o),
  .link_alive_o  (link_alive_o)
);

`default_nettype wire
